FILE: design/wamt_pkg.sv
// Package for weighted_adaptive_match_threshold: Q24 constants, the CORDIC
// arctangent table, the tanh series coefficients, small reciprocals and the Q24 rounding helper.
// No dependencies.
`default_nettype none
package wamt_pkg;

	localparam logic [25:0] Q_ONE    = 26'd16777216;
	localparam logic [63:0] Q_HALF   = 64'd8388608;
	localparam logic [27:0] HALF_PI  = 28'd26353589;
	localparam logic [31:0] TENTH    = 32'd1677722;
	localparam logic [63:0] RATE_MAX = 64'd268435456;
	localparam logic [31:0] TANH_C9  = 32'd366909;

	localparam logic [1:0] CFG_MAX_RANGE  = 2'd0;
	localparam logic [1:0] CFG_MIN_MOTION = 2'd1;
	localparam logic [1:0] CFG_INIT_THR   = 2'd2;

	function automatic logic [23:0] atan_lut(input logic [4:0] i);
		logic [23:0] v;
		unique case (i)
			5'd0: v = 24'd13176795;
			5'd1: v = 24'd7778716;
			5'd2: v = 24'd4110060;
			5'd3: v = 24'd2086331;
			5'd4: v = 24'd1047214;
			5'd5: v = 24'd524117;
			5'd6: v = 24'd262123;
			5'd7: v = 24'd131069;
			5'd8: v = 24'd65536;
			5'd9: v = 24'd32768;
			5'd10: v = 24'd16384;
			5'd11: v = 24'd8192;
			5'd12: v = 24'd4096;
			5'd13: v = 24'd2048;
			5'd14: v = 24'd1024;
			5'd15: v = 24'd512;
			5'd16: v = 24'd256;
			5'd17: v = 24'd128;
			5'd18: v = 24'd64;
			5'd19: v = 24'd32;
			5'd20: v = 24'd16;
			5'd21: v = 24'd8;
			5'd22: v = 24'd4;
			5'd23: v = 24'd2;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

	function automatic logic [25:0] tanh_coef(input logic [1:0] i);
		logic [25:0] v;
		unique case (i)
			2'd0: v = 26'd905437;
			2'd1: v = 26'd2236962;
			2'd2: v = 26'd5592405;
			2'd3: v = Q_ONE;
		endcase
		return v;
	endfunction

	// ceil(2^31 / k): floor(x * recip_k(k) >> 31) == floor(x / k) for x below 2^23
	function automatic logic [31:0] recip_k(input logic [2:0] k);
		logic [31:0] v;
		unique case (k)
			3'd1: v = 32'd2147483648;
			3'd2: v = 32'd1073741824;
			3'd3: v = 32'd715827883;
			3'd4: v = 32'd536870912;
			3'd5: v = 32'd429496730;
			3'd6: v = 32'd357913942;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic [39:0] rnd24(input logic [63:0] p);
		logic [63:0] s;
		s = p + Q_HALF;
		return s[63:24];
	endfunction

endpackage
`default_nettype wire

FILE: design/weighted_adaptive_match_threshold.sv
// From the accepting edge to m_tvalid, two 32-step roots and a 24-step CORDIC always run;
// the trend weight (56- and 50-step divides) runs only with a nonzero previous error; the
// mean (64-step divide) and its 32-step root only once samples are counted.
// One item at a time: the next beat can be taken in the cycle after the result is in the
// output register, and later if a waiting result still holds that register.
// Reset (arst_n low): registers to their defaults, error history and sums cleared.
`default_nettype none
module weighted_adaptive_match_threshold
	import wamt_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// quat_w, quat_x, quat_y, quat_z, shift_x, shift_y, shift_z
	input  wire logic [159:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// threshold, error
	output logic [63:0]       m_tdata,
	// used_initial
	output logic              m_tuser
);

	localparam logic [32:0] EPS = 33'(((1 << FRAC_BITS) + 500000) / 1000000);

	typedef enum logic [5:0] {
		ST_IDLE, ST_TX, ST_TY, ST_TZ, ST_TSUM, ST_TSQRT, ST_QX, ST_QY, ST_QZ, ST_QSUM,
		ST_VSQRT, ST_CORDIC, ST_ANG, ST_UMUL, ST_U, ST_U2M, ST_U2, ST_PM, ST_P, ST_THM,
		ST_TH, ST_ROTM, ST_ROT, ST_WCHK, ST_RDIV, ST_EM, ST_EDL, ST_EDIV, ST_EQ, ST_SQEM,
		ST_SQE, ST_THL, ST_THDIV, ST_SQM, ST_SQ, ST_HIM, ST_LOM, ST_LO, ST_ACC, ST_RES,
		ST_SDIV, ST_RSQRT, ST_OUT
	} state_t;

	state_t state_q;

	logic [31:0] max_range_q, min_motion_q, init_thr_q;
	logic [31:0] prev_err_q, smp_cnt_q;
	logic        has_prev_q;
	logic [63:0] sse_q;

	logic [15:0] qw_q, qx_q, qy_q, qz_q;
	logic [31:0] tx_q, ty_q, tz_q;
	logic [63:0] acc_q, prod_q;
	logic [31:0] trans_q;

	logic [63:0] sqv_q;
	logic [33:0] sqr_q;
	logic [31:0] sqt_q;
	logic [63:0] dvn_q;
	logic [32:0] dvr_q, dvd_q;
	logic [6:0]  cnt_q;

	logic signed [27:0] cx_q, cy_q, ang_q;
	logic [4:0]  ci_q;
	logic        zero_q;
	logic [25:0] angle_q;
	logic [31:0] u_q, u2_q, t_q;
	logic [1:0]  kc_q;
	logic [31:0] err_q;
	logic        fall_q;
	logic [22:0] s_q;
	logic [24:0] e_q;
	logic [23:0] ex_q;
	logic [2:0]  k_q;
	logic [25:0] weight_q;
	logic [63:0] sq_q, hi_q, term_q;
	logic [31:0] thr_q;
	logic        used_q;

	logic [63:0] m_tdata_q;
	logic        m_tuser_q, m_tvalid_q;

	logic [31:0] mul_a, mul_b;
	logic [39:0] pr;

	logic [35:0] sq_rt, sq_tr;
	logic        sq_ge;
	logic [33:0] sq_rn;
	logic [31:0] sq_root_n;

	logic [33:0] dv_t;
	logic        dv_ge;
	logic [32:0] dv_rn;
	logic [63:0] dv_nn;

	logic signed [27:0] cx_sh, cy_sh, atan_v;
	logic        fall_c;
	logic [31:0] mag_c;
	logic [28:0] r_sat;
	logic [25:0] one_m_e, one_p_e, th_d;
	logic [49:0] th_num;
	logic [32:0] tot;
	logic [64:0] t65, s65;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_TX: begin mul_a = tx_q; mul_b = tx_q; end
			ST_TY: begin mul_a = ty_q; mul_b = ty_q; end
			ST_TZ: begin mul_a = tz_q; mul_b = tz_q; end
			ST_QX: begin mul_a = 32'(qx_q); mul_b = 32'(qx_q); end
			ST_QY: begin mul_a = 32'(qy_q); mul_b = 32'(qy_q); end
			ST_QZ: begin mul_a = 32'(qz_q); mul_b = 32'(qz_q); end
			ST_UMUL: begin mul_a = 32'(angle_q); mul_b = TENTH; end
			ST_U2M: begin mul_a = u_q; mul_b = u_q; end
			ST_PM: begin mul_a = t_q; mul_b = u2_q; end
			ST_THM: begin mul_a = u_q; mul_b = t_q; end
			ST_ROTM: begin mul_a = max_range_q; mul_b = t_q; end
			ST_EM: begin mul_a = 32'(s_q); mul_b = 32'(e_q); end
			ST_EDIV: begin mul_a = 32'(ex_q); mul_b = recip_k(k_q); end
			ST_SQEM: begin mul_a = 32'(e_q); mul_b = 32'(e_q); end
			ST_SQM: begin mul_a = err_q; mul_b = err_q; end
			ST_HIM: begin mul_a = sq_q[63:32]; mul_b = 32'(weight_q); end
			ST_LOM: begin mul_a = sq_q[31:0]; mul_b = 32'(weight_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		pr = rnd24(prod_q);

		sq_rt = {sqr_q, sqv_q[63:62]};
		sq_tr = {2'b00, sqt_q, 2'b01};
		sq_ge = (sq_rt >= sq_tr);
		sq_rn = sq_ge ? 34'(sq_rt - sq_tr) : sq_rt[33:0];
		sq_root_n = {sqt_q[30:0], sq_ge};

		dv_t  = {dvr_q, dvn_q[63]};
		dv_ge = (dv_t >= {1'b0, dvd_q});
		dv_rn = dv_ge ? 33'(dv_t - {1'b0, dvd_q}) : dv_t[32:0];
		dv_nn = {dvn_q[62:0], dv_ge};

		cx_sh  = cy_q >>> ci_q;
		cy_sh  = cx_q >>> ci_q;
		atan_v = $signed({4'b0000, atan_lut(ci_q)});

		fall_c = (err_q < prev_err_q);
		mag_c  = fall_c ? (prev_err_q - err_q) : (err_q - prev_err_q);
		r_sat  = (dv_nn > RATE_MAX) ? RATE_MAX[28:0] : dv_nn[28:0];

		one_m_e = Q_ONE - 26'(e_q);
		one_p_e = Q_ONE + 26'(e_q);
		th_num  = {one_m_e, 24'd0} + 50'(one_p_e[25:1]);
		th_d    = 26'((dv_nn[27:0] + 28'd2) >> 2);

		tot = {1'b0, trans_q} + {1'b0, pr[31:0]};
		t65 = {1'b0, hi_q[55:0], 8'd0} + 65'(pr);
		s65 = {1'b0, sse_q} + {1'b0, term_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_range_q <= 32'd6553600;
			min_motion_q <= 32'd6554;
			init_thr_q <= 32'd131072;
			prev_err_q <= '0;
			has_prev_q <= 1'b0;
			sse_q <= '0;
			smp_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
			qw_q <= '0; qx_q <= '0; qy_q <= '0; qz_q <= '0;
			tx_q <= '0; ty_q <= '0; tz_q <= '0;
			acc_q <= '0; prod_q <= '0; trans_q <= '0;
			sqv_q <= '0; sqr_q <= '0; sqt_q <= '0;
			dvn_q <= '0; dvr_q <= '0; dvd_q <= '0; cnt_q <= '0;
			cx_q <= '0; cy_q <= '0; ang_q <= '0; ci_q <= '0; zero_q <= 1'b0;
			angle_q <= '0; u_q <= '0; u2_q <= '0; t_q <= '0; kc_q <= '0;
			err_q <= '0; fall_q <= 1'b0; s_q <= '0; e_q <= '0; ex_q <= '0; k_q <= '0;
			weight_q <= '0; sq_q <= '0; hi_q <= '0; term_q <= '0;
			thr_q <= '0; used_q <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;

			if (cfg_we) begin
				if (cfg_index == CFG_MAX_RANGE) max_range_q <= cfg_data;
				if (cfg_index == CFG_MIN_MOTION) min_motion_q <= cfg_data;
				if (cfg_index == CFG_INIT_THR) init_thr_q <= cfg_data;
			end

			if (m_tready && (state_q != ST_OUT)) m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						qw_q <= s_tdata[15] ? 16'(-s_tdata[15:0]) : s_tdata[15:0];
						qx_q <= s_tdata[31] ? 16'(-s_tdata[31:16]) : s_tdata[31:16];
						qy_q <= s_tdata[47] ? 16'(-s_tdata[47:32]) : s_tdata[47:32];
						qz_q <= s_tdata[63] ? 16'(-s_tdata[63:48]) : s_tdata[63:48];
						tx_q <= s_tdata[95] ? 32'(-s_tdata[95:64]) : s_tdata[95:64];
						ty_q <= s_tdata[127] ? 32'(-s_tdata[127:96]) : s_tdata[127:96];
						tz_q <= s_tdata[159] ? 32'(-s_tdata[159:128]) : s_tdata[159:128];
						acc_q <= '0;
						state_q <= ST_TX;
					end
				end
				ST_TX: state_q <= ST_TY;
				ST_TY: begin acc_q <= acc_q + prod_q; state_q <= ST_TZ; end
				ST_TZ: begin acc_q <= acc_q + prod_q; state_q <= ST_TSUM; end
				ST_TSUM: begin
					sqv_q <= acc_q + prod_q;
					sqr_q <= '0;
					sqt_q <= '0;
					cnt_q <= 7'd32;
					state_q <= ST_TSQRT;
				end
				ST_TSQRT: begin
					sqv_q <= {sqv_q[61:0], 2'b00};
					sqr_q <= sq_rn;
					sqt_q <= sq_root_n;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						trans_q <= sq_root_n;
						acc_q <= '0;
						state_q <= ST_QX;
					end
				end
				ST_QX: state_q <= ST_QY;
				ST_QY: begin acc_q <= acc_q + prod_q; state_q <= ST_QZ; end
				ST_QZ: begin acc_q <= acc_q + prod_q; state_q <= ST_QSUM; end
				ST_QSUM: begin
					sqv_q <= (acc_q + prod_q) << 16;
					sqr_q <= '0;
					sqt_q <= '0;
					cnt_q <= 7'd32;
					state_q <= ST_VSQRT;
				end
				ST_VSQRT: begin
					sqv_q <= {sqv_q[61:0], 2'b00};
					sqr_q <= sq_rn;
					sqt_q <= sq_root_n;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						cx_q <= $signed({4'b0000, qw_q, 8'd0});
						cy_q <= $signed({4'b0000, sq_root_n[23:0]});
						ang_q <= '0;
						ci_q <= '0;
						zero_q <= (qw_q == 16'd0) && (sq_root_n == 32'd0);
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (!cy_q[27]) begin
						cx_q <= cx_q + cx_sh;
						cy_q <= cy_q - cy_sh;
						ang_q <= ang_q + atan_v;
					end else begin
						cx_q <= cx_q - cx_sh;
						cy_q <= cy_q + cy_sh;
						ang_q <= ang_q - atan_v;
					end
					ci_q <= ci_q + 5'd1;
					if (ci_q == 5'd23) state_q <= ST_ANG;
				end
				ST_ANG: begin
					if (zero_q || ang_q[27]) angle_q <= '0;
					else if (ang_q > HALF_PI) angle_q <= {HALF_PI[24:0], 1'b0};
					else angle_q <= {ang_q[24:0], 1'b0};
					state_q <= ST_UMUL;
				end
				ST_UMUL: state_q <= ST_U;
				ST_U: begin u_q <= pr[31:0]; state_q <= ST_U2M; end
				ST_U2M: state_q <= ST_U2;
				ST_U2: begin
					u2_q <= pr[31:0];
					t_q <= TANH_C9;
					kc_q <= '0;
					state_q <= ST_PM;
				end
				ST_PM: state_q <= ST_P;
				ST_P: begin
					t_q <= 32'(tanh_coef(kc_q)) - pr[31:0];
					kc_q <= kc_q + 2'd1;
					state_q <= (kc_q == 2'd3) ? ST_THM : ST_PM;
				end
				ST_THM: state_q <= ST_TH;
				ST_TH: begin t_q <= pr[31:0]; state_q <= ST_ROTM; end
				ST_ROTM: state_q <= ST_ROT;
				ST_ROT: begin
					err_q <= tot[32] ? 32'hFFFF_FFFF : tot[31:0];
					state_q <= ST_WCHK;
				end
				ST_WCHK: begin
					if (has_prev_q && (prev_err_q != 32'd0)) begin
						fall_q <= fall_c;
						dvn_q <= {mag_c, 32'd0};
						dvr_q <= '0;
						dvd_q <= {1'b0, prev_err_q} + EPS;
						cnt_q <= 7'd56;
						state_q <= ST_RDIV;
					end else begin
						weight_q <= Q_ONE;
						state_q <= ST_SQM;
					end
				end
				ST_RDIV: begin
					dvn_q <= dv_nn;
					dvr_q <= dv_rn;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						s_q <= 23'((r_sat + 29'd32) >> 6);
						e_q <= 25'(Q_ONE);
						k_q <= 3'd6;
						state_q <= ST_EM;
					end
				end
				ST_EM: state_q <= ST_EDL;
				ST_EDL: begin
					ex_q <= pr[23:0];
					state_q <= ST_EDIV;
				end
				ST_EDIV: state_q <= ST_EQ;
				ST_EQ: begin
					e_q <= 25'(Q_ONE - {2'b00, prod_q[54:31]});
					if (k_q == 3'd1) begin
						k_q <= 3'd6;
						state_q <= ST_SQEM;
					end else begin
						k_q <= k_q - 3'd1;
						state_q <= ST_EM;
					end
				end
				ST_SQEM: state_q <= ST_SQE;
				ST_SQE: begin
					e_q <= pr[24:0];
					k_q <= k_q - 3'd1;
					state_q <= (k_q == 3'd1) ? ST_THL : ST_SQEM;
				end
				ST_THL: begin
					dvn_q <= {th_num, 14'd0};
					dvr_q <= '0;
					dvd_q <= 33'(one_p_e);
					cnt_q <= 7'd50;
					state_q <= ST_THDIV;
				end
				ST_THDIV: begin
					dvn_q <= dv_nn;
					dvr_q <= dv_rn;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						weight_q <= fall_q ? (Q_ONE - th_d) : (Q_ONE + th_d);
						state_q <= ST_SQM;
					end
				end
				ST_SQM: state_q <= ST_SQ;
				ST_SQ: begin
					sq_q <= prod_q;
					prev_err_q <= err_q;
					has_prev_q <= 1'b1;
					state_q <= (err_q > min_motion_q) ? ST_HIM : ST_RES;
				end
				ST_HIM: state_q <= ST_LOM;
				ST_LOM: begin hi_q <= prod_q; state_q <= ST_LO; end
				ST_LO: begin
					if (hi_q[63:56] != 8'd0 || t65[64]) term_q <= '1;
					else term_q <= t65[63:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sse_q <= s65[64] ? '1 : s65[63:0];
					if (smp_cnt_q != 32'hFFFF_FFFF) smp_cnt_q <= smp_cnt_q + 32'd1;
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (smp_cnt_q == 32'd0) begin
						thr_q <= init_thr_q;
						used_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						used_q <= 1'b0;
						dvn_q <= sse_q;
						dvr_q <= '0;
						dvd_q <= {1'b0, smp_cnt_q};
						cnt_q <= 7'd64;
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					dvn_q <= dv_nn;
					dvr_q <= dv_rn;
					if (cnt_q == 7'd1) begin
						sqv_q <= dv_nn;
						sqr_q <= '0;
						sqt_q <= '0;
						cnt_q <= 7'd32;
						state_q <= ST_RSQRT;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_RSQRT: begin
					sqv_q <= {sqv_q[61:0], 2'b00};
					sqr_q <= sq_rn;
					sqt_q <= sq_root_n;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						thr_q <= sq_root_n;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q <= {err_q, thr_q};
						m_tuser_q <= used_q;
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for weighted_adaptive_match_threshold: drives pose deviations on the
// input stream, predicts threshold and model error per beat, checks the output stream.
// Depends on wamt_pkg and the design top.
`default_nettype none
module tb_top
	import wamt_pkg::*;
();

	typedef struct {
		logic [31:0] thr;
		logic [31:0] err;
		logic        init;
	} thr_result_t;

	localparam logic [1:0] CFG_NONE = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic         m_tuser;

	weighted_adaptive_match_threshold u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	localparam longint unsigned ONE24 = 64'd16777216;
	localparam longint unsigned HALF24 = 64'd8388608;

	longint unsigned range_q, motion_q, init_thr_q;
	longint unsigned last_err, sse_sum, n_samples;
	bit              have_last;
	thr_result_t     expected_q[$];
	int              errors;
	int              idle_pct, stall_pct;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("** weighted_adaptive_match_threshold: FAILED **");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned q24_mul(longint unsigned a, longint unsigned b);
		return (a * b + HALF24) >> 24;
	endfunction

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned rot_angle(longint w, longint x, longint y, longint z);
		longint unsigned vsq;
		longint cx, cy, acc, dx, dy;
		vsq = x * x + y * y + z * z;
		cx = (w < 0 ? -w : w) * 256;
		cy = longint'(int_sqrt(vsq << 16));
		acc = 0;
		if (cx == 0 && cy == 0) return 0;
		for (int i = 0; i < 24; i++) begin
			dx = shr_floor(cy, i);
			dy = shr_floor(cx, i);
			if (cy >= 0) begin
				cx += dx; cy -= dy; acc += longint'(atan_lut(5'(i)));
			end else begin
				cx -= dx; cy += dy; acc -= longint'(atan_lut(5'(i)));
			end
		end
		if (acc < 0) acc = 0;
		if (acc > 26353589) acc = 26353589;
		return longint'(acc) * 2;
	endfunction

	function automatic longint unsigned tanh_series(longint unsigned u);
		longint unsigned u2, t;
		u2 = q24_mul(u, u);
		t = 366909;
		t = 905437 - q24_mul(t, u2);
		t = 2236962 - q24_mul(t, u2);
		t = 5592405 - q24_mul(t, u2);
		t = ONE24 - q24_mul(t, u2);
		return q24_mul(u, t);
	endfunction

	function automatic longint unsigned trend_weight(longint unsigned e, longint unsigned p);
		longint unsigned den, mag, r, s, ex, th, d;
		bit falling;
		den = p + ((64'd65536 + 500000) / 1000000);
		falling = e < p;
		mag = falling ? p - e : e - p;
		r = (mag << 24) / den;
		if (r > (64'd16 << 24)) r = 64'd16 << 24;
		s = (r + 32) >> 6;
		ex = ONE24;
		for (int k = 6; k >= 1; k--) ex = ONE24 - q24_mul(s, ex) / k;
		for (int k = 0; k < 6; k++) ex = q24_mul(ex, ex);
		th = (((ONE24 - ex) << 24) + ((ONE24 + ex) >> 1)) / (ONE24 + ex);
		d = (th + 2) >> 2;
		return falling ? ONE24 - d : ONE24 + d;
	endfunction

	function automatic thr_result_t predict_threshold(logic [159:0] d);
		longint qw, qx, qy, qz, sx, sy, sz;
		longint unsigned trans, u, rot, tot, e, wt, sq, hi, lo, term, thr;
		thr_result_t res;
		qw = $signed(d[15:0]);   qx = $signed(d[31:16]);
		qy = $signed(d[47:32]);  qz = $signed(d[63:48]);
		sx = $signed(d[95:64]);  sy = $signed(d[127:96]); sz = $signed(d[159:128]);
		if (sx < 0) sx = -sx;
		if (sy < 0) sy = -sy;
		if (sz < 0) sz = -sz;
		trans = int_sqrt(sx * sx + sy * sy + sz * sz);
		u = (rot_angle(qw, qx, qy, qz) * 1677722 + HALF24) >> 24;
		rot = (range_q * tanh_series(u) + HALF24) >> 24;
		tot = trans + rot;
		e = tot > 64'hFFFFFFFF ? 64'hFFFFFFFF : tot;
		wt = ONE24;
		if (have_last && last_err != 0) wt = trend_weight(e, last_err);
		last_err = e;
		have_last = 1;
		if (e > motion_q) begin
			sq = e * e;
			hi = (sq >> 32) * wt;
			lo = ((sq & 64'hFFFFFFFF) * wt + HALF24) >> 24;
			if (hi >= (64'd1 << 56)) begin
				term = '1;
			end else begin
				term = hi << 8;
				term = (term > ~lo) ? '1 : term + lo;
			end
			sse_sum = (sse_sum > ~term) ? '1 : sse_sum + term;
			if (n_samples != 64'hFFFFFFFF) n_samples++;
		end
		res.init = (n_samples == 0);
		thr = res.init ? init_thr_q : int_sqrt(sse_sum / n_samples);
		if (thr > 64'hFFFFFFFF) thr = 64'hFFFFFFFF;
		res.thr = thr[31:0];
		res.err = e[31:0];
		return res;
	endfunction

	always @(posedge clk) begin
		thr_result_t x;
		if (s_tvalid && s_tready)
			expected_q.insert(expected_q.size(), predict_threshold(s_tdata));
		if (m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				x = expected_q.pop_front();
				if (m_tdata[31:0] !== x.thr) begin
					$error("threshold exp %0d got %0d", x.thr, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== x.err) begin
					$error("pose_error exp %0d got %0d", x.err, m_tdata[63:32]);
					errors++;
				end
				if (m_tuser !== x.init) begin
					$error("used_initial exp %0d got %0d", x.init, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_pose(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tdata <= {sz, sy, sx, z, y, x, w};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (500) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
		case (idx)
			CFG_MAX_RANGE:  range_q = val;
			CFG_MIN_MOTION: motion_q = val;
			CFG_INIT_THR:   init_thr_q = val;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] rand_quat();
		return 16'($urandom_range(32768) - 16384);
	endfunction

	function automatic logic [31:0] rand_shift(int mode);
		case (mode)
			0: return 32'($urandom_range(131072) - 65536);
			1: return 32'($urandom_range(2000000) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_pose(0, 0, 0, 0, 0, 0, 0);
		send_pose(16384, 0, 0, 0, 0, 0, 0);
		send_pose(0, 16384, 0, 0, 0, 0, 0);
		send_pose(-16384, 0, 0, -16384, 32'h10000, 0, 0);
		send_pose(16384, 16384, 16384, 16384, 0, 0, 0);
		send_pose(0, -16384, -16384, -16384, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_pose(0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
		send_pose(0, 0, 0, 0, 32'hFFFFFFFF, 0, 0);
		send_pose(16000, 100, -100, 50, 32'h20000, 32'hFFFE0000, 32'h8000);
		send_pose(16000, 200, 300, -50, 32'h1000, 0, 0);
		send_pose(16384, 0, 0, 0, 32'h100, 0, 0);
		send_pose(4, 3, 0, 0, 0, 32'h40000, 0);
		send_pose(-1, 1, -1, 1, 32'h80000000, 32'h7FFFFFFF, 32'h12345678);
	endtask

	task automatic test_random(int count);
		logic [15:0] w, x, y, z;
		int m;
		for (int i = 0; i < count; i++) begin
			m = $urandom_range(9);
			if (m < 7) begin
				w = 16'(16384 - $urandom_range(600));
				x = 16'($urandom_range(1200) - 600);
				y = 16'($urandom_range(1200) - 600);
				z = 16'($urandom_range(1200) - 600);
			end else begin
				w = rand_quat(); x = rand_quat(); y = rand_quat(); z = rand_quat();
			end
			send_pose(w, x, y, z, rand_shift(m % 3), rand_shift(m % 3),
				rand_shift(m == 9 ? 2 : 0));
		end
	endtask

	task automatic test_config_extremes();
		drain();
		write_reg(CFG_MAX_RANGE, 32'hFFFFFFFF);
		write_reg(CFG_MIN_MOTION, 0);
		write_reg(CFG_INIT_THR, 32'hFFFFFFFF);
		test_random(150);
		drain();
		write_reg(CFG_MAX_RANGE, 0);
		write_reg(CFG_MIN_MOTION, 32'hFFFFFFFF);
		write_reg(CFG_INIT_THR, 0);
		test_random(100);
		drain();
		write_reg(CFG_MAX_RANGE, 32'd6553600);
		write_reg(CFG_MIN_MOTION, 32'd6554);
		write_reg(CFG_INIT_THR, 32'd131072);
		write_reg(CFG_NONE, $urandom);
	endtask

	task automatic test_idling();
		idle_pct = 0;   stall_pct = 0;  test_random(300);
		idle_pct = 62;  stall_pct = 0;  test_random(300);
		idle_pct = 0;   stall_pct = 62; test_random(300);
		idle_pct = 20;  stall_pct = 20; test_random(290);
	endtask

	initial begin
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		m_tready = 0;
		range_q = 6553600;
		motion_q = 6554;
		init_thr_q = 131072;
		last_err = 0;
		have_last = 0;
		sse_sum = 0;
		n_samples = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_config_extremes();
		test_idling();
		drain();
		if (errors == 0)
			$display("** weighted_adaptive_match_threshold: PASSED **");
		else
			$display("** weighted_adaptive_match_threshold: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

FILE: weighted_adaptive_match_threshold.f
design/wamt_pkg.sv
design/weighted_adaptive_match_threshold.sv
verif/tb_top.sv
